### hdl/token_bucket_packet_shaper_core_defines.svh
// Assertion macros for the token bucket shaper.
// All of them expect clk and arst_n in the scope where they are used.
`ifndef TOKEN_BUCKET_PACKET_SHAPER_CORE_DEFINES_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_CORE_DEFINES_SVH

// Condition that holds at every edge out of reset.
`define TBS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TBS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TBS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tbs_pkg.sv
`timescale 1ns / 1ps

package tbs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int NEED_W      = 16;
	localparam int ID_W        = 32;
	localparam int ENTRY_W     = ID_W + NEED_W;
	localparam int STATUS_W    = 3;

	localparam logic [NEED_W-1:0] DEPTH_RESET = 16'd10;

	typedef enum logic [STATUS_W-1:0] {
		ST_TOKEN_ADDED   = 3'd0,
		ST_TOKEN_DROPPED = 3'd1,
		ST_PKT_QUEUED    = 3'd2,
		ST_PKT_TOO_BIG   = 3'd3,
		ST_QUEUE_FULL    = 3'd4
	} status_code_t;

	// Controller to datapath commands
	typedef struct packed {
		logic arrive; // apply the incoming item (transfer cycle)
		logic settle; // head release check and result load
	} dp_cmd_t;

	function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] ptr);
		logic [QPTR_W-1:0] nxt;
		if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

endpackage

### hdl/tbs_ram.sv
`timescale 1ns / 1ps

module tbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hdl/tbs_ctrl.sv
`timescale 1ns / 1ps
`include "token_bucket_packet_shaper_core_defines.svh"

module tbs_ctrl import tbs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SETTLE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load;

	assign in_stall   = (state_q != ST_IDLE);
	assign load       = (state_q == ST_SETTLE) && (!out_valid_q || !out_stall);
	assign cmd.arrive = (state_q == ST_IDLE) && in_valid;
	assign cmd.settle = load;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_SETTLE;
				end
				ST_SETTLE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TBS_ASSERT_IMP(a_no_overwrite, cmd.settle, !(out_valid_q && out_stall), "result overwritten while held")
	`TBS_ASSERT_NXT(a_arrive_to_fetch, cmd.arrive, (state_q == ST_FETCH) && in_stall, "arrival did not start fetch")

endmodule

### hdl/tbs_dp.sv
`timescale 1ns / 1ps
`include "token_bucket_packet_shaper_core_defines.svh"

module tbs_dp import tbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	input  logic                cfg_wen,
	input  logic [NEED_W-1:0]   cfg_wdata,
	input  logic                op,
	input  logic [NEED_W-1:0]   packet_need,
	output logic [STATUS_W-1:0] status,
	output logic                released,
	output logic [ID_W-1:0]     released_id,
	output logic [NEED_W-1:0]   released_need,
	output logic [NEED_W-1:0]   tokens_now,
	output logic [QCNT_W-1:0]   queue_count
);

	logic [NEED_W-1:0] bucket_depth_q;
	logic [NEED_W-1:0] tokens_q;
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QCNT_W-1:0] count_q;
	logic [ID_W-1:0]   arrival_q;
	status_code_t      status_q;

	logic [STATUS_W-1:0] res_status_q;
	logic                res_rel_q;
	logic [ID_W-1:0]     res_id_q;
	logic [NEED_W-1:0]   res_need_q;
	logic [NEED_W-1:0]   res_tokens_q;
	logic [QCNT_W-1:0]   res_count_q;

	logic [ID_W-1:0]    arr_id;
	logic               tok_room;
	status_code_t       arr_status;
	logic               wr_en;
	logic [ENTRY_W-1:0] rd_data;
	logic [ID_W-1:0]    head_id;
	logic [NEED_W-1:0]  head_need;
	logic               rel_ok;
	logic [NEED_W-1:0]  tokens_after;
	logic [QCNT_W-1:0]  count_after;

	assign arr_id   = arrival_q + 1'b1;
	assign tok_room = tokens_q < bucket_depth_q;

	always_comb begin
		wr_en = 1'b0;
		if (!op) begin
			arr_status = tok_room ? ST_TOKEN_ADDED : ST_TOKEN_DROPPED;
		end else if (packet_need > bucket_depth_q) begin
			arr_status = ST_PKT_TOO_BIG;
		end else if (count_q == QCNT_W'(QUEUE_DEPTH)) begin
			arr_status = ST_QUEUE_FULL;
		end else begin
			arr_status = ST_PKT_QUEUED;
			wr_en      = cmd.arrive;
		end
	end

	tbs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_wait_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data ({arr_id, packet_need}),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	assign head_id      = rd_data[ENTRY_W-1:NEED_W];
	assign head_need    = rd_data[NEED_W-1:0];
	assign rel_ok       = (count_q != '0) && (tokens_q >= head_need);
	assign tokens_after = rel_ok ? (tokens_q - head_need) : tokens_q;
	assign count_after  = rel_ok ? (count_q - 1'b1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_depth_q <= DEPTH_RESET;
			tokens_q       <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			arrival_q      <= '0;
		end else begin
			if (cfg_wen) begin
				bucket_depth_q <= cfg_wdata;
			end
			if (cmd.arrive) begin
				if (!op) begin
					if (tok_room) begin
						tokens_q <= tokens_q + 1'b1;
					end
				end else begin
					arrival_q <= arr_id;
					if (wr_en) begin
						tail_q  <= next_slot(tail_q);
						count_q <= count_q + 1'b1;
					end
				end
			end
			if (cmd.settle && rel_ok) begin
				tokens_q <= tokens_after;
				head_q   <= next_slot(head_q);
				count_q  <= count_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arrive) begin
			status_q <= arr_status;
		end
		if (cmd.settle) begin
			res_status_q <= status_q;
			res_rel_q    <= rel_ok;
			res_id_q     <= rel_ok ? head_id : '0;
			res_need_q   <= rel_ok ? head_need : '0;
			res_tokens_q <= tokens_after;
			res_count_q  <= count_after;
		end
	end

	assign status        = res_status_q;
	assign released      = res_rel_q;
	assign released_id   = res_id_q;
	assign released_need = res_need_q;
	assign tokens_now    = res_tokens_q;
	assign queue_count   = res_count_q;

	`TBS_ASSERT_ALWAYS(a_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "wait count beyond queue depth")
	`TBS_ASSERT_IMP(a_ptr_match, (count_q == '0) || (count_q == QCNT_W'(QUEUE_DEPTH)), head_q == tail_q, "pointers disagree with count")
	`TBS_ASSERT_NXT(a_token_add, cmd.arrive && !op && tok_room, tokens_q == NEED_W'($past(tokens_q) + 1'b1), "token not added")

endmodule

### hdl/token_bucket_packet_shaper_core.sv
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_stall   op, packet_need
// out      out_valid / out_stall status, released, released_id, released_need,
//                                tokens_now, queue_count
// cfg      cfg_wen               cfg_wdata (bucket depth)
//
// Each item goes through transfer, wait-store read and release check, in that order. The
// wait-store read step comes from the registered read port of the wait store RAM.
// arst_n clears bucket (0 tokens), queue pointers, sequence number and sets
// the depth to 10; the wait store itself is not cleared.
// A result held under out_stall does not block the next input transfer; only
// the release step waits for the output register to free up.
module token_bucket_packet_shaper_core import tbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wen,
	input  logic [NEED_W-1:0]   cfg_wdata,
	// input items
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [NEED_W-1:0]   packet_need,
	// results
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic                released,
	output logic [ID_W-1:0]     released_id,
	output logic [NEED_W-1:0]   released_need,
	output logic [NEED_W-1:0]   tokens_now,
	output logic [QCNT_W-1:0]   queue_count
);

	// arrive: item applied on its transfer cycle (token add, enqueue, drop)
	// settle: head entry is checked against the bucket and the result loaded
	dp_cmd_t cmd;

	// Sequencer: idle -> fetch (RAM read at head) -> settle
	tbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Bucket, queue pointers, wait store and result register
	tbs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.op            (op),
		.packet_need   (packet_need),
		.status        (status),
		.released      (released),
		.released_id   (released_id),
		.released_need (released_need),
		.tokens_now    (tokens_now),
		.queue_count   (queue_count)
	);

endmodule

### sim/token_bucket_packet_shaper_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the token bucket shaper core.
// Items go in through the in channel. At each transfer the bench works out,
// with its own model of the bucket and the waiting queue, the one result the
// item must cause. Results are checked in order at each out transfer.
// The bucket depth is only rewritten while nothing is in flight.
module token_bucket_packet_shaper_core_tb;
	import tbs_pkg::*;

	// item kinds on the op input
	localparam logic OP_TOKEN  = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	localparam int MAX_REPORTS = 10;
	// about 2000 items plus worst-case gaps and stalls, taken many times over
	localparam int CYCLE_LIMIT = 400000;
	// quiet time after the last result; longer than the core needs for one item
	localparam int SETTLE_CYCLES = 6;

	// one packet waiting for tokens
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [NEED_W-1:0] need;
	} waiting_pkt_t;

	// everything the core reports for one item
	typedef struct {
		status_code_t      status;
		logic              released;
		logic [ID_W-1:0]   released_id;
		logic [NEED_W-1:0] released_need;
		logic [NEED_W-1:0] tokens_now;
		logic [QCNT_W-1:0] queue_count;
	} shaper_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [NEED_W-1:0]   cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                op = OP_TOKEN;
	logic [NEED_W-1:0]   packet_need = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                released;
	logic [ID_W-1:0]     released_id;
	logic [NEED_W-1:0]   released_need;
	logic [NEED_W-1:0]   tokens_now;
	logic [QCNT_W-1:0]   queue_count;

	// shadow state of the shaper
	logic [NEED_W-1:0] model_depth = DEPTH_RESET;
	logic [NEED_W-1:0] model_tokens = '0;
	logic [ID_W-1:0]   model_seq = '0;
	waiting_pkt_t      model_waiting[$];

	// results still owed by the core, oldest first
	shaper_result_t pending_results[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	token_bucket_packet_shaper_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.packet_need   (packet_need),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.released      (released),
		.released_id   (released_id),
		.released_need (released_need),
		.tokens_now    (tokens_now),
		.queue_count   (queue_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Next state of the shaper for one item, and the result it reports.
	// Token first, or packet admission; then at most one head release.
	function automatic shaper_result_t shape_item(input logic op_i,
			input logic [NEED_W-1:0] need_i);
		shaper_result_t r;
		waiting_pkt_t   head;
		r.released      = 1'b0;
		r.released_id   = '0;
		r.released_need = '0;
		if (op_i == OP_TOKEN) begin
			if (model_tokens < model_depth) begin
				model_tokens = model_tokens + 1'b1;
				r.status = ST_TOKEN_ADDED;
			end else begin
				r.status = ST_TOKEN_DROPPED;
			end
		end else begin
			// dropped packets still use up a sequence number
			model_seq = model_seq + 1'b1;
			if (need_i > model_depth) begin
				r.status = ST_PKT_TOO_BIG;   // checked ahead of queue full
			end else if (model_waiting.size() >= QUEUE_DEPTH) begin
				r.status = ST_QUEUE_FULL;
			end else begin
				model_waiting.push_back('{id: model_seq, need: need_i});
				r.status = ST_PKT_QUEUED;
			end
		end
		if (model_waiting.size() > 0 && model_tokens >= model_waiting[0].need) begin
			head            = model_waiting.pop_front();
			r.released      = 1'b1;
			r.released_id   = head.id;
			r.released_need = head.need;
			model_tokens    = model_tokens - head.need;
		end
		r.tokens_now  = model_tokens;
		r.queue_count = QCNT_W'(model_waiting.size());
		return r;
	endfunction

	// Offer one item and hold it until the transfer. Called at a rising edge;
	// returns at the edge of the transfer with in_valid still high.
	task automatic send_item(input logic op_i, input logic [NEED_W-1:0] need_i);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= op_i;
		packet_need <= need_i;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(shape_item(op_i, need_i));
	endtask

	// Wait until every result is back and the core has gone quiet.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Depth write, only once the core is idle.
	task automatic write_depth(input logic [NEED_W-1:0] depth);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= depth;
		@(posedge clk);
		cfg_wen     <= 1'b0;
		model_depth = depth;
	endtask

	// Fill the bucket to a small depth; the last token overflows.
	task automatic test_bucket_fill;
		write_depth(16'd3);
		repeat (4) send_item(OP_TOKEN, '0);
	endtask

	// Depth cut below the bucket content: the count stays, tokens are dropped,
	// a packet above the new depth is too big, a zero-need one leaves at once.
	task automatic test_depth_below_bucket;
		write_depth(16'd1);
		send_item(OP_TOKEN, 16'hFFFF);
		send_item(OP_PACKET, 16'd2);
		send_item(OP_PACKET, 16'd1);
		send_item(OP_PACKET, 16'd0);
	endtask

	// Depth of zero: all tokens dropped, only zero-need packets admitted.
	task automatic test_depth_zero;
		write_depth(16'd0);
		send_item(OP_TOKEN, '0);
		send_item(OP_PACKET, 16'd0);
		send_item(OP_PACKET, 16'd1);
	endtask

	// Fill the queue at the largest depth, overflow it with the largest need,
	// then show the too-big check winning over the full check.
	task automatic test_queue_full;
		write_depth(16'hFFFF);
		repeat (QUEUE_DEPTH) send_item(OP_PACKET, 16'd3);
		send_item(OP_PACKET, 16'hFFFF);
		write_depth(16'd2);
		send_item(OP_PACKET, 16'd3);
		send_item(OP_PACKET, 16'd2);
	endtask

	// Mixed traffic: mostly needs the bucket can serve so the queue keeps
	// moving and the pointers wrap, with some oversized and fully random needs.
	task automatic test_random_traffic(input logic [NEED_W-1:0] depth,
			input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned num_items);
		int unsigned       pick;
		int unsigned       near_cap;
		logic [NEED_W-1:0] need_v;
		write_depth(depth);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		near_cap = (depth < 8) ? depth : 8;
		repeat (num_items) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				need_v = NEED_W'($urandom_range(near_cap, 0));
			end else if (pick < 88) begin
				need_v = NEED_W'($urandom_range(depth, 0));
			end else begin
				need_v = NEED_W'($urandom());
			end
			// need is random on token items too; the core must ignore it
			if ($urandom_range(99) < 55) begin
				send_item(OP_TOKEN, NEED_W'($urandom()));
			end else begin
				send_item(OP_PACKET, need_v);
			end
		end
	endtask

	// receiver side: random stalls at the rate of the current phase
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// result checker: each out transfer against the oldest expectation
	always @(posedge clk) begin
		shaper_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: status=%0d released=%0d id=%0d",
						status, released, released_id);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || released !== want.released ||
						released_id !== want.released_id ||
						released_need !== want.released_need ||
						tokens_now !== want.tokens_now ||
						queue_count !== want.queue_count) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("mismatch exp: status=%0d rel=%0d id=%0d need=%0d tok=%0d q=%0d",
							want.status, want.released, want.released_id,
							want.released_need, want.tokens_now, want.queue_count);
						$display("         got: status=%0d rel=%0d id=%0d need=%0d tok=%0d q=%0d",
							status, released, released_id, released_need,
							tokens_now, queue_count);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		// reset once, released on a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the first idling mix
		send_idle_pct  = 21;
		recv_stall_pct = 55;
		test_bucket_fill();
		test_depth_below_bucket();
		test_depth_zero();
		test_queue_full();

		// random part: sender idles less than receiver, then the reverse,
		// then a stretch with no idling at all
		test_random_traffic(16'd6, 21, 55, 680);
		test_random_traffic(16'd30, 55, 21, 680);
		test_random_traffic(16'd12, 0, 0, 680);

		drain();
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
